// File: hw/rtl/tak_pkg.sv
// Shared types, constants and helper functions of the tilt angle Kalman filter.
`timescale 1ns / 1ps
package tak_pkg;

  localparam int unsigned CfgW    = 28;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_ANGLE_Q = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BIAS_Q  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MEAS_R  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_DT      = 2'd3;

  localparam logic [CfgW-1:0] AngleQRst = 28'd16777;
  localparam logic [CfgW-1:0] BiasQRst  = 28'd50332;
  localparam logic [CfgW-1:0] MeasRRst  = 28'd8388608;
  localparam logic [CfgW-1:0] DtRst     = 28'd234881;

  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned CordicSteps = 22;
  localparam int unsigned SqrtSteps   = 32;
  localparam int unsigned DivSteps    = 56;

  localparam logic signed [23:0] NinetyDeg = 24'sd5898240;
  localparam logic signed [31:0] CovOne    = 32'sd16777216;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [27:0] gyro_rate;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] accel_angle;
    logic signed [27:0] filtered_angle;
    logic signed [27:0] corrected_rate;
  } out_item_t;

  typedef struct packed {
    logic signed [23:0] accel_angle;
    logic signed [27:0] gyro_rate;
  } meas_t;

  function automatic logic [21:0] atan_deg(input logic [4:0] idx);
    logic [21:0] v;
    case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
    logic signed [31:0] r;
    if (v > 44'sh0007FFFFFFF) r = 32'sh7FFFFFFF;
    else if (v < -44'sh00080000000) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [27:0] sat28(input logic signed [32:0] v);
    logic signed [27:0] r;
    if (v > 33'sh007FFFFFF) r = 28'sh7FFFFFF;
    else if (v < -33'sh008000000) r = 28'sh8000000;
    else r = v[27:0];
    return r;
  endfunction

endpackage

// File: hw/rtl/tak_front.sv
// Front end: accelerometer tilt angle by bit-serial square root and CORDIC.
`timescale 1ns / 1ps
module tak_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tak_pkg::in_item_t in_i,
  output logic             full_o,
  output logic             m_valid_o,
  output tak_pkg::meas_t   m_o,
  input  logic             m_ready_i
);

  typedef enum logic [1:0] {F_IDLE, F_SQRT, F_CORDIC, F_PUSH} state_e;

  state_e             state_q;
  logic [4:0]         cnt_q;
  logic [63:0]        sq_n_q;
  logic [32:0]        rem_q;
  logic [31:0]        root_q;
  logic signed [34:0] x_q, y_q;
  logic signed [23:0] z_q;
  logic [15:0]        az_abs_q;
  logic               az_neg_q;
  logic signed [27:0] gyro_q;
  logic signed [23:0] acc_q;

  logic signed [31:0] sq_x, sq_y;
  logic [32:0]        sq_sum;
  logic [15:0]        az_abs;
  logic [34:0]        sq_sh, sq_trial, sq_diff;
  logic               sq_ge;
  logic [32:0]        rem_d;
  logic [31:0]        root_d;
  logic signed [34:0] xs, ys, x_d, y_d;
  logic signed [23:0] z_d, tab, z_clamp;

  assign sq_x     = in_i.accel_x * in_i.accel_x;
  assign sq_y     = in_i.accel_y * in_i.accel_y;
  assign sq_sum   = {1'b0, sq_x} + {1'b0, sq_y};
  assign az_abs   = in_i.accel_z[15] ? 16'(-in_i.accel_z) : in_i.accel_z;

  assign sq_sh    = {rem_q, sq_n_q[63:62]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;
  assign sq_diff  = sq_sh - sq_trial;
  assign rem_d    = sq_ge ? sq_diff[32:0] : sq_sh[32:0];
  assign root_d   = {root_q[30:0], sq_ge};

  assign xs  = x_q >>> cnt_q;
  assign ys  = y_q >>> cnt_q;
  assign tab = {2'b00, tak_pkg::atan_deg(cnt_q)};

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    if (y_q > 35'sd0) begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      z_d = z_q + tab;
    end else if (y_q < 35'sd0) begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      z_d = z_q - tab;
    end
  end

  always_comb begin
    if (z_d < 24'sd0) z_clamp = 24'sd0;
    else if (z_d > tak_pkg::NinetyDeg) z_clamp = tak_pkg::NinetyDeg;
    else z_clamp = z_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      cnt_q    <= '0;
      sq_n_q   <= '0;
      rem_q    <= '0;
      root_q   <= '0;
      x_q      <= '0;
      y_q      <= '0;
      z_q      <= '0;
      az_abs_q <= '0;
      az_neg_q <= 1'b0;
      gyro_q   <= '0;
      acc_q    <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (push_i) begin
            sq_n_q   <= {sq_sum[31:0], 32'd0};
            rem_q    <= '0;
            root_q   <= '0;
            cnt_q    <= '0;
            az_abs_q <= az_abs;
            az_neg_q <= in_i.accel_z[15];
            gyro_q   <= in_i.gyro_rate;
            if (in_i.accel_z == 16'sd0) begin
              acc_q   <= tak_pkg::NinetyDeg;
              state_q <= F_PUSH;
            end else begin
              state_q <= F_SQRT;
            end
          end
        end
        F_SQRT: begin
          sq_n_q <= {sq_n_q[61:0], 2'b00};
          rem_q  <= rem_d;
          root_q <= root_d;
          cnt_q  <= cnt_q + 5'd1;
          if (cnt_q == 5'(tak_pkg::SqrtSteps - 1)) begin
            x_q     <= {3'b000, az_abs_q, 16'd0};
            y_q     <= {3'b000, root_d};
            z_q     <= '0;
            cnt_q   <= '0;
            state_q <= F_CORDIC;
          end
        end
        F_CORDIC: begin
          x_q   <= x_d;
          y_q   <= y_d;
          z_q   <= z_d;
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(tak_pkg::CordicSteps - 1)) begin
            acc_q   <= az_neg_q ? -z_clamp : z_clamp;
            state_q <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (m_ready_i) state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  assign full_o            = state_q != F_IDLE;
  assign m_valid_o         = state_q == F_PUSH;
  assign m_o.accel_angle   = acc_q;
  assign m_o.gyro_rate     = gyro_q;

endmodule

// File: hw/rtl/tak_fifo.sv
// Short queue of measurements between the front end and the filter core.
`timescale 1ns / 1ps
module tak_fifo #(
  parameter int unsigned DEPTH = tak_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  tak_pkg::meas_t wdata_i,
  output logic           full_o,
  input  logic           rd_i,
  output tak_pkg::meas_t rdata_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  tak_pkg::meas_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o  = cnt_q == CntW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) cnt_q <= cnt_q + CntW'(1);
      else if (do_rd && !do_wr) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

// File: hw/rtl/tak_back.sv
// Filter core: Kalman prediction and update on a shared multiplier and two serial dividers.
`timescale 1ns / 1ps
module tak_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tak_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tak_pkg::CfgW-1:0]         cfg_data_i,
  input  logic                             q_valid_i,
  input  tak_pkg::meas_t                   q_data_i,
  output logic                             q_pop_o,
  output logic                             empty_o,
  input  logic                             pop_i,
  output tak_pkg::out_item_t               out_o
);

  typedef enum logic [3:0] {
    B_IDLE, B_PR0, B_PR1, B_PR2, B_PR3, B_PR4, B_DIV, B_GAIN,
    B_U0, B_U1, B_U2, B_U3, B_U4, B_U5, B_U6, B_OUT
  } state_e;

  state_e             state_q;
  logic [5:0]         cnt_q;
  logic [27:0]        qa_q, qg_q, r_q, dt_q;
  logic signed [31:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q, k0_q, k1_q;
  logic signed [23:0] acc_q;
  logic signed [27:0] gyro_q;
  logic [32:0]        e_q, rem0_q, rem1_q;
  logic [55:0]        n0_q, n1_q;
  logic               neg0_q, neg1_q;
  logic signed [66:0] prod_q;
  tak_pkg::out_item_t out_q;
  logic               out_valid_q;

  logic signed [32:0] rate, err;
  logic signed [33:0] d_arg, e_sum;
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic [66:0]        prod_d;
  logic signed [66:0] rnd;
  logic signed [42:0] mr;
  logic [31:0]        abs00, abs10;
  logic [33:0]        sh0, sh1, df0, df1;
  logic               ge0, ge1, e_pos, out_load;

  function automatic logic signed [31:0] gain_sat(input logic [55:0] q, input logic neg);
    logic signed [31:0] r;
    if (neg) r = (q > 56'h80000000) ? 32'sh80000000 : -q[31:0];
    else r = (q > 56'h7FFFFFFF) ? 32'sh7FFFFFFF : q[31:0];
    return r;
  endfunction

  function automatic logic signed [43:0] acc_ext(input logic signed [31:0] p,
                                                 input logic signed [42:0] m);
    return {{12{p[31]}}, p} + {m[42], m};
  endfunction

  function automatic logic signed [43:0] sub_ext(input logic signed [31:0] p,
                                                 input logic signed [42:0] m);
    return {{12{p[31]}}, p} - {m[42], m};
  endfunction

  assign rate  = {{5{gyro_q[27]}}, gyro_q} - {bias_q[31], bias_q};
  assign err   = {{9{acc_q[23]}}, acc_q} - {ang_q[31], ang_q};
  assign d_arg = $signed({6'd0, qa_q}) - {{2{p01_q[31]}}, p01_q}
               - {{2{p10_q[31]}}, p10_q};
  assign e_sum = $signed({6'd0, r_q}) + {{2{p00_q[31]}}, p00_q};
  assign e_pos = !e_sum[33] && (e_sum != 34'sd0);
  assign abs00 = p00_q[31] ? 32'(-p00_q) : p00_q;
  assign abs10 = p10_q[31] ? 32'(-p10_q) : p10_q;

  always_comb begin
    unique case (state_q)
      B_PR0:                 mul_a = {rate[32], rate};
      B_PR1:                 mul_a = d_arg;
      B_PR2:                 mul_a = {{2{p11_q[31]}}, p11_q};
      B_PR3:                 mul_a = $signed({6'd0, qg_q});
      B_U0, B_U2, B_U4:      mul_a = {{2{k0_q[31]}}, k0_q};
      B_U1, B_U3, B_U5:      mul_a = {{2{k1_q[31]}}, k1_q};
      default:               mul_a = '0;
    endcase
    unique case (state_q)
      B_PR0, B_PR1, B_PR2, B_PR3: mul_b = $signed({5'd0, dt_q});
      B_U0, B_U1:                 mul_b = {p00_q[31], p00_q};
      B_U2, B_U3:                 mul_b = {p01_q[31], p01_q};
      B_U4, B_U5:                 mul_b = err;
      default:                    mul_b = '0;
    endcase
  end

  assign prod_d = {{33{mul_a[33]}}, mul_a} * {{34{mul_b[32]}}, mul_b};
  assign rnd    = prod_q + 67'sd8388608;
  assign mr     = rnd[66:24];

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign sh0 = {rem0_q, n0_q[55]};
  assign sh1 = {rem1_q, n1_q[55]};
  assign ge0 = sh0 >= {1'b0, e_q};
  assign ge1 = sh1 >= {1'b0, e_q};
  assign df0 = sh0 - {1'b0, e_q};
  assign df1 = sh1 - {1'b0, e_q};

  assign q_pop_o  = (state_q == B_IDLE) && q_valid_i;
  assign out_load = (state_q == B_OUT) && (!out_valid_q || pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= '0;
      qa_q        <= tak_pkg::AngleQRst;
      qg_q        <= tak_pkg::BiasQRst;
      r_q         <= tak_pkg::MeasRRst;
      dt_q        <= tak_pkg::DtRst;
      ang_q       <= '0;
      bias_q      <= '0;
      p00_q       <= tak_pkg::CovOne;
      p01_q       <= '0;
      p10_q       <= '0;
      p11_q       <= tak_pkg::CovOne;
      k0_q        <= '0;
      k1_q        <= '0;
      acc_q       <= '0;
      gyro_q      <= '0;
      e_q         <= '0;
      rem0_q      <= '0;
      rem1_q      <= '0;
      n0_q        <= '0;
      n1_q        <= '0;
      neg0_q      <= 1'b0;
      neg1_q      <= 1'b0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tak_pkg::CFG_ANGLE_Q: qa_q <= cfg_data_i;
          tak_pkg::CFG_BIAS_Q:  qg_q <= cfg_data_i;
          tak_pkg::CFG_MEAS_R:  r_q  <= cfg_data_i;
          tak_pkg::CFG_DT:      dt_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (pop_i && out_valid_q && !out_load) out_valid_q <= 1'b0;

      unique case (state_q)
        B_IDLE: begin
          if (q_valid_i) begin
            acc_q   <= q_data_i.accel_angle;
            gyro_q  <= q_data_i.gyro_rate;
            state_q <= B_PR0;
          end
        end
        B_PR0: state_q <= B_PR1;
        B_PR1: begin
          ang_q   <= tak_pkg::sat32(acc_ext(ang_q, mr));
          state_q <= B_PR2;
        end
        B_PR2: begin
          p00_q   <= tak_pkg::sat32(acc_ext(p00_q, mr));
          state_q <= B_PR3;
        end
        B_PR3: begin
          p01_q   <= tak_pkg::sat32(sub_ext(p01_q, mr));
          p10_q   <= tak_pkg::sat32(sub_ext(p10_q, mr));
          state_q <= B_PR4;
        end
        B_PR4: begin
          p11_q <= tak_pkg::sat32(acc_ext(p11_q, mr));
          if (e_pos) begin
            e_q     <= e_sum[32:0];
            n0_q    <= {abs00, 24'd0};
            n1_q    <= {abs10, 24'd0};
            neg0_q  <= p00_q[31];
            neg1_q  <= p10_q[31];
            rem0_q  <= '0;
            rem1_q  <= '0;
            cnt_q   <= '0;
            state_q <= B_DIV;
          end else begin
            state_q <= B_OUT;
          end
        end
        B_DIV: begin
          rem0_q <= ge0 ? df0[32:0] : sh0[32:0];
          rem1_q <= ge1 ? df1[32:0] : sh1[32:0];
          n0_q   <= {n0_q[54:0], ge0};
          n1_q   <= {n1_q[54:0], ge1};
          cnt_q  <= cnt_q + 6'd1;
          if (cnt_q == 6'(tak_pkg::DivSteps - 1)) state_q <= B_GAIN;
        end
        B_GAIN: begin
          k0_q    <= gain_sat(n0_q, neg0_q);
          k1_q    <= gain_sat(n1_q, neg1_q);
          state_q <= B_U0;
        end
        B_U0: state_q <= B_U1;
        B_U1: begin
          p00_q   <= tak_pkg::sat32(sub_ext(p00_q, mr));
          state_q <= B_U2;
        end
        B_U2: begin
          p10_q   <= tak_pkg::sat32(sub_ext(p10_q, mr));
          state_q <= B_U3;
        end
        B_U3: begin
          p01_q   <= tak_pkg::sat32(sub_ext(p01_q, mr));
          state_q <= B_U4;
        end
        B_U4: begin
          p11_q   <= tak_pkg::sat32(sub_ext(p11_q, mr));
          state_q <= B_U5;
        end
        B_U5: begin
          ang_q   <= tak_pkg::sat32(acc_ext(ang_q, mr));
          state_q <= B_U6;
        end
        B_U6: begin
          bias_q  <= tak_pkg::sat32(acc_ext(bias_q, mr));
          state_q <= B_OUT;
        end
        B_OUT: begin
          if (out_load) begin
            out_q.accel_angle    <= acc_q;
            out_q.filtered_angle <= tak_pkg::sat28({ang_q[31], ang_q});
            out_q.corrected_rate <= tak_pkg::sat28(rate);
            out_valid_q          <= 1'b1;
            state_q              <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign empty_o = !out_valid_q;
  assign out_o   = out_q;

`ifndef SYNTHESIS
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_DIV |-> e_q != '0)
    else $error("divisor is zero during division");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_DIV |-> cnt_q < 6'(tak_pkg::DivSteps))
    else $error("division step count out of range");

  a_pop_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> state_q == B_PR0)
    else $error("queue read without starting prediction");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == B_OUT)
    else $error("result appeared outside the output step");
`endif

endmodule

// File: hw/rtl/tilt_angle_kalman_filter.sv
// Top level of the tilt angle Kalman filter: front end, queue and filter core.
`timescale 1ns / 1ps
// Usage:
//   Input channel: drive in_i and raise push_i; a sample is taken on a clock edge
//   with push_i high and full_o low. Result channel: while empty_o is low, out_o
//   holds the oldest result; pop_i high on a clock edge takes it.
//   Configuration: cfg_we_i, cfg_idx_i and cfg_data_i write one tuning register
//   per cycle; write only while no sample is in flight.
//   Processing: the front end runs a 32-step square root and a 22-step CORDIC,
//   then a hand-off state (only the hand-off when accel_z is zero); the filter core follows.
//   Pace: set by the 56-step serial gain divider in the filter core, which takes
//   a new sample only once it is through with the last; the front end works on
//   the next sample meanwhile and a two-entry queue decouples the two.
//   Reset: asynchronous, active low; clears the filter state to zero angle and
//   bias with unit covariance and loads the default tuning values.
//   Receiver stall: a held result blocks the core at its output step; the queue
//   then fills and full_o stays high until pop_i drains the result.
module tilt_angle_kalman_filter #(
  parameter int unsigned QUEUE_DEPTH = tak_pkg::QueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  tak_pkg::in_item_t           in_i,
  output logic                        full_o,
  output logic                        empty_o,
  input  logic                        pop_i,
  output tak_pkg::out_item_t          out_o,
  input  logic                        cfg_we_i,
  input  logic [tak_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tak_pkg::CfgW-1:0]    cfg_data_i
);

  tak_pkg::meas_t f_meas, q_meas;
  logic           f_valid, q_full, q_empty, q_pop;

  tak_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .in_i      (in_i),
    .full_o    (full_o),
    .m_valid_o (f_valid),
    .m_o       (f_meas),
    .m_ready_i (!q_full)
  );

  tak_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (f_valid),
    .wdata_i (f_meas),
    .full_o  (q_full),
    .rd_i    (q_pop),
    .rdata_o (q_meas),
    .empty_o (q_empty)
  );

  tak_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_valid_i  (!q_empty),
    .q_data_i   (q_meas),
    .q_pop_o    (q_pop),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .out_o      (out_o)
  );

endmodule

// File: tb/tb_tilt_angle_kalman_filter.sv
// Self-checking testbench of the tilt angle Kalman filter with its own predictor.
`timescale 1ns / 1ps
module tb_tilt_angle_kalman_filter;

  localparam longint CycleLimit = 3000000;
  localparam int     HoldCycles = 900;

  class kalman_scoreboard;
    logic [tak_pkg::CfgW-1:0] cfg_reg [4];
    longint angle_est, bias_est, p_aa, p_ab, p_ba, p_bb;
    tak_pkg::out_item_t expected_q [$];
    int errors;

    function new();
      cfg_reg[tak_pkg::CFG_ANGLE_Q] = tak_pkg::AngleQRst;
      cfg_reg[tak_pkg::CFG_BIAS_Q]  = tak_pkg::BiasQRst;
      cfg_reg[tak_pkg::CFG_MEAS_R]  = tak_pkg::MeasRRst;
      cfg_reg[tak_pkg::CFG_DT]      = tak_pkg::DtRst;
      angle_est = 0;
      bias_est  = 0;
      p_aa = 64'sd1 <<< 24;
      p_ab = 0;
      p_ba = 0;
      p_bb = 64'sd1 <<< 24;
      errors = 0;
    endfunction

    function void set_reg(logic [tak_pkg::CfgIdxW-1:0] idx, logic [tak_pkg::CfgW-1:0] val);
      cfg_reg[idx] = val;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint clip32(longint v);
      return clip(v, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function longint mul_round(longint a, longint b);
      return (a * b + (64'sd1 <<< 23)) >>> 24;
    endfunction

    function longint int_sqrt(bit [63:0] n);
      bit [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return longint'(res);
    endfunction

    function longint tilt_deg(longint ax, longint ay, longint az);
      bit [63:0] sq;
      longint x, y, z, xs, ys;
      z = 0;
      if (az == 0) return longint'(tak_pkg::NinetyDeg);
      sq = 64'(ax * ax + ay * ay);
      y = int_sqrt(sq << 32);
      x = (az < 0 ? -az : az) * 65536;
      for (int i = 0; i < tak_pkg::CordicSteps; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x += ys; y -= xs; z += longint'(tak_pkg::atan_deg(i[4:0]));
        end else if (y < 0) begin
          x -= ys; y += xs; z -= longint'(tak_pkg::atan_deg(i[4:0]));
        end
      end
      z = clip(z, 0, longint'(tak_pkg::NinetyDeg));
      return az < 0 ? -z : z;
    endfunction

    function void note_sample(tak_pkg::in_item_t s);
      longint dt, gyro, acc, d00, d01, d11, e, k0, k1, err, a0, a1, b0, b1;
      tak_pkg::out_item_t r;
      dt   = longint'(cfg_reg[tak_pkg::CFG_DT]);
      gyro = longint'(s.gyro_rate);
      acc  = tilt_deg(longint'(s.accel_x), longint'(s.accel_y), longint'(s.accel_z));
      angle_est = clip32(angle_est + mul_round(gyro - bias_est, dt));
      d00 = mul_round(longint'(cfg_reg[tak_pkg::CFG_ANGLE_Q]) - p_ab - p_ba, dt);
      d01 = mul_round(p_bb, dt);
      d11 = mul_round(longint'(cfg_reg[tak_pkg::CFG_BIAS_Q]), dt);
      p_aa = clip32(p_aa + d00);
      p_ab = clip32(p_ab - d01);
      p_ba = clip32(p_ba - d01);
      p_bb = clip32(p_bb + d11);
      err = acc - angle_est;
      e = longint'(cfg_reg[tak_pkg::CFG_MEAS_R]) + p_aa;
      if (e > 0) begin
        k0 = clip32(p_aa * 16777216 / e);
        k1 = clip32(p_ba * 16777216 / e);
        a0 = p_aa; a1 = p_ab; b0 = p_ba; b1 = p_bb;
        p_aa = clip32(a0 - mul_round(k0, a0));
        p_ab = clip32(a1 - mul_round(k0, a1));
        p_ba = clip32(b0 - mul_round(k1, a0));
        p_bb = clip32(b1 - mul_round(k1, a1));
        angle_est = clip32(angle_est + mul_round(k0, err));
        bias_est  = clip32(bias_est + mul_round(k1, err));
      end
      r.accel_angle    = acc[23:0];
      r.filtered_angle = 28'(clip(angle_est, -134217728, 134217727));
      r.corrected_rate = 28'(clip(gyro - bias_est, -134217728, 134217727));
      expected_q.push_back(r);
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(tak_pkg::out_item_t got);
      tak_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        report("unexpected transaction", 0, 0);
        return;
      end
      want = expected_q.pop_front();
      if (got.accel_angle !== want.accel_angle)
        report("accel_angle", got.accel_angle, want.accel_angle);
      if (got.filtered_angle !== want.filtered_angle)
        report("filtered_angle", got.filtered_angle, want.filtered_angle);
      if (got.corrected_rate !== want.corrected_rate)
        report("corrected_rate", got.corrected_rate, want.corrected_rate);
    endtask
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         push_i;
  tak_pkg::in_item_t            in_i;
  logic                         full_o;
  logic                         empty_o;
  logic                         pop_i;
  tak_pkg::out_item_t           out_o;
  logic                         cfg_we_i;
  logic [tak_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [tak_pkg::CfgW-1:0]     cfg_data_i;

  kalman_scoreboard sb;
  int     tx_idle_pct;
  int     rx_idle_pct;
  int     stall_req;
  int     stall_seen;
  int     hold_left;
  longint cycles;

  tilt_angle_kalman_filter DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .in_i       (in_i),
    .full_o     (full_o),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tilt_angle_kalman_filter regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop_i && !empty_o) sb.check_result(out_o);
      if (stall_req != stall_seen) begin
        stall_seen <= stall_req;
        hold_left  <= HoldCycles;
        pop_i      <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        pop_i     <= 1'b0;
      end else begin
        pop_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic write_reg(logic [tak_pkg::CfgIdxW-1:0] idx, logic [tak_pkg::CfgW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic load_tuning(logic [tak_pkg::CfgW-1:0] qa, logic [tak_pkg::CfgW-1:0] qg,
                             logic [tak_pkg::CfgW-1:0] r, logic [tak_pkg::CfgW-1:0] dt);
    write_reg(tak_pkg::CFG_ANGLE_Q, qa);
    write_reg(tak_pkg::CFG_BIAS_Q, qg);
    write_reg(tak_pkg::CFG_MEAS_R, r);
    write_reg(tak_pkg::CFG_DT, dt);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_sample(tak_pkg::in_item_t s);
    push_i <= 1'b1;
    in_i   <= s;
    do @(posedge clk_i); while (full_o);
    sb.note_sample(s);
    if ($urandom_range(99) < tx_idle_pct) begin
      push_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    push_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic tak_pkg::in_item_t make_sample(logic signed [15:0] ax,
                                                    logic signed [15:0] ay,
                                                    logic signed [15:0] az,
                                                    logic signed [27:0] g);
    tak_pkg::in_item_t s;
    s.accel_x = ax; s.accel_y = ay; s.accel_z = az; s.gyro_rate = g;
    return s;
  endfunction

  function automatic tak_pkg::in_item_t random_sample();
    tak_pkg::in_item_t s;
    bit [95:0] raw;
    if ($urandom_range(99) < 70) begin
      s.accel_x   = 16'($signed($urandom_range(0, 40000)) - 20000);
      s.accel_y   = 16'($signed($urandom_range(0, 40000)) - 20000);
      s.accel_z   = 16'($signed($urandom_range(0, 40000)) - 20000);
      s.gyro_rate = 28'($signed($urandom_range(0, 26214400)) - 13107200);
      if ($urandom_range(19) == 0) s.accel_z = '0;
      if ($urandom_range(19) == 0) begin
        s.accel_x = '0; s.accel_y = '0;
      end
    end else begin
      raw = {$urandom, $urandom, $urandom};
      s = raw[75:0];
    end
    return s;
  endfunction

  task automatic directed_samples();
    send_sample(make_sample(16'sd0, 16'sd0, 16'sd16384, 28'sd0));
    send_sample(make_sample(16'sd1000, 16'sd2000, 16'sd0, 28'sd65536));
    send_sample(make_sample(16'sd0, 16'sd0, 16'sd0, -28'sd65536));
    send_sample(make_sample(16'sd0, 16'sd0, -16'sd16384, 28'sd0));
    send_sample(make_sample(16'sd32767, 16'sd32767, 16'sd32767, 28'sh7FFFFFF));
    send_sample(make_sample(-16'sd32768, -16'sd32768, -16'sd32768, 28'sh8000000));
    send_sample(make_sample(-16'sd32768, -16'sd32768, 16'sd1, 28'sh7FFFFFF));
    send_sample(make_sample(16'sd32767, -16'sd32768, -16'sd1, 28'sh8000000));
    send_sample(make_sample(16'sd1, 16'sd0, 16'sd32767, 28'sd1));
    send_sample(make_sample(16'sd0, -16'sd1, -16'sd32768, -28'sd1));
    send_sample(make_sample(16'sd11585, 16'sd11585, 16'sd16384, 28'sd655360));
    send_sample(make_sample(-16'sd16384, 16'sd0, 16'sd16384, -28'sd655360));
    send_sample(make_sample(16'sd16384, 16'sd0, -16'sd1, 28'sd0));
    send_sample(make_sample(16'sd0, 16'sd16384, 16'sd0, 28'sh7FFFFFF));
    send_sample(make_sample(16'sd0, 16'sd0, 16'sd1, 28'sh8000000));
    send_sample(make_sample(-16'sd1, -16'sd1, -16'sd1, -28'sd1));
  endtask

  task automatic random_samples(int n);
    repeat (n) send_sample(random_sample());
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    push_i = 1'b0;
    in_i = '0;
    pop_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = tak_pkg::CFG_ANGLE_Q;
    cfg_data_i = '0;
    tx_idle_pct = 19;
    rx_idle_pct = 57;
    stall_req = 0;
    stall_seen = 0;
    hold_left = 0;
    cycles = 0;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_samples();
    random_samples(300);
    drain();

    load_tuning(28'hFFFFFFF, 28'hFFFFFFF, 28'd1, 28'hFFFFFFF);
    stall_req <= stall_req + 1;
    random_samples(200);
    drain();

    tx_idle_pct = 57;
    rx_idle_pct = 19;
    load_tuning(28'd0, 28'd0, 28'hFFFFFFF, 28'd1);
    random_samples(200);
    drain();

    load_tuning(28'd16777, 28'd50332, 28'd8388608, 28'd0);
    directed_samples();
    random_samples(250);
    drain();

    load_tuning(28'($urandom), 28'($urandom), 28'($urandom_range(1, 268435455)),
                28'($urandom_range(1, 268435455)));
    stall_req <= stall_req + 1;
    random_samples(200);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    load_tuning(28'($urandom_range(0, 200000)), 28'($urandom_range(0, 200000)),
                28'($urandom_range(1, 33554432)), 28'($urandom_range(1, 2000000)));
    random_samples(250);
    drain();

    load_tuning(tak_pkg::AngleQRst, tak_pkg::BiasQRst, tak_pkg::MeasRRst, tak_pkg::DtRst);
    random_samples(320);
    drain();

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tilt_angle_kalman_filter regression: pass");
    end else begin
      $display("tilt_angle_kalman_filter regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/tak_pkg.sv
hw/rtl/tak_front.sv
hw/rtl/tak_fifo.sv
hw/rtl/tak_back.sv
hw/rtl/tilt_angle_kalman_filter.sv
tb/tb_tilt_angle_kalman_filter.sv
